[design/tcm_pkg.sv]
// Shared types, constants and codes for the terrace curve mapper.
`default_nettype none
package tcm_pkg;
  localparam int MAX_POINTS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    KIND_MAP   = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_SPARSE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_ADDCHK, S_INS, S_SHWR,
    S_MRD0, S_MRD1, S_MRD2, S_DIV, S_SQ, S_MUL, S_SUM, S_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the item value and clear the result
    logic idx_clr;    // index <= 0
    logic idx_inc;    // index <= index + 1
    logic idx_dec;    // index <= index - 1
    logic idx_cnt;    // index <= count
    logic pos_cap;    // remember index as the insert position
    logic rd_prev;    // address the table at index - 1 instead of index
    logic cap_v0;     // capture read data as v0
    logic res_edge;   // take read data as the result
    logic div_start;  // capture read data as v1 and start the divider
    logic wr_shift;   // write read data at index
    logic wr_value;   // write item value at index
    logic cnt_inc;
    logic cnt_clr;
    logic sq;
    logic mul;
    logic sum;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic lt;         // value below read data
    logic eq;         // value equals read data
    logic idx_at_cnt; // index has reached count
    logic idx_at_pos; // index has reached the insert position
    logic idx_zero;
    logic full;
    logic sparse;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

[design/tcm_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module tcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[design/tcm_datapath.sv]
// Datapath: point table, index and count, divider and multiplier.
`default_nettype none
module tcm_datapath
  import tcm_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic [31:0] in_value,
  input  wire logic        invert,
  output sts_t             sts,
  output logic [31:0]      result
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int QW = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] ONE_A = {1'b1, {FRAC_BITS{1'b0}}};

  logic [CW-1:0] idx_r, cnt_r, pos_r;
  logic [CW-1:0] idx_m1;
  logic signed [31:0] val_r, v0_r, v1_r;
  logic [31:0] rdata, wdata;
  logic        we;
  logic [AW-1:0] addr;

  // Divider: restoring, one quotient bit per cycle.
  logic [32:0] rem_r, dvs_r;
  logic [33:0] rem_sh, rem_sub;
  logic [FRAC_BITS-1:0] quo_r;
  logic [QW-1:0] dcnt_r;
  logic [FRAC_BITS:0] alpha, asq_r;
  logic [2*FRAC_BITS+1:0] sq_full;
  logic signed [32:0] diff;
  logic signed [FRAC_BITS+34:0] prod_r, prod_sh;
  logic [31:0] end0;

  assign idx_m1 = idx_r - CW'(1);
  assign addr   = cmd.rd_prev ? idx_m1[AW-1:0] : idx_r[AW-1:0];
  assign we     = cmd.wr_shift | cmd.wr_value;
  assign wdata  = cmd.wr_value ? val_r : rdata;

  tcm_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
      dcnt_r <= '0;
    end else begin
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + CW'(1);
      else if (cmd.idx_dec) idx_r <= idx_m1;
      else if (cmd.idx_cnt) idx_r <= cnt_r;
      if (cmd.cnt_clr) cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + CW'(1);
      if (cmd.div_start) dcnt_r <= QW'(FRAC_BITS);
      else if (dcnt_r != '0) dcnt_r <= dcnt_r - QW'(1);
    end
  end

  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.load) val_r <= in_value;
    if (cmd.pos_cap) pos_r <= idx_r;
    if (cmd.cap_v0) v0_r <= rdata;
    if (cmd.div_start) begin
      // The sample lies in [v0, v1), so the remainder starts below the divisor.
      v1_r  <= rdata;
      rem_r <= {val_r[31], val_r} - {v0_r[31], v0_r};
      dvs_r <= {rdata[31], rdata} - {v0_r[31], v0_r};
      quo_r <= '0;
    end else if (dcnt_r != '0) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= rem_sub[32:0];
        quo_r <= {quo_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[32:0];
        quo_r <= {quo_r[FRAC_BITS-2:0], 1'b0};
      end
    end
    if (cmd.sq) asq_r <= sq_full[2*FRAC_BITS:FRAC_BITS];
    if (cmd.mul) prod_r <= $signed({1'b0, asq_r}) * diff;
    if (cmd.load) result <= '0;
    else if (cmd.res_edge) result <= rdata;
    else if (cmd.sum) result <= end0 + prod_sh[31:0];
  end

  // With invert set the segment ends swap and alpha becomes one minus alpha.
  assign alpha   = invert ? ONE_A - {1'b0, quo_r} : {1'b0, quo_r};
  assign sq_full = alpha * alpha;
  assign diff    = invert ? ({v0_r[31], v0_r} - {v1_r[31], v1_r})
                          : ({v1_r[31], v1_r} - {v0_r[31], v0_r});
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign end0    = invert ? v1_r : v0_r;

  assign sts.lt = $signed(val_r) < $signed(rdata);
  assign sts.eq = val_r == rdata;
  assign sts.idx_at_cnt = idx_r == cnt_r;
  assign sts.idx_at_pos = idx_r == pos_r;
  assign sts.idx_zero = idx_r == '0;
  assign sts.full = cnt_r == CW'(MAX_POINTS);
  assign sts.sparse = cnt_r < CW'(2);
  assign sts.div_done = dcnt_r == '0;
endmodule
`default_nettype wire

[design/tcm_ctrl.sv]
// Controller state machine for add, clear and map items.
`default_nettype none
module tcm_ctrl
  import tcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [1:0]  in_kind,
  input  wire sts_t        sts,
  output logic             busy,
  output cmd_t             cmd,
  output logic             done,
  output status_t          st_out
);
  state_t  state_r, state_nxt;
  kind_t   kind_r;
  status_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_NONE;
      st_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r <= st_nxt;
      if (state_r == S_IDLE && start) kind_r <= kind_t'(in_kind);
    end
  end

  assign busy   = state_r != S_IDLE;
  assign done   = state_r == S_DONE;
  assign st_out = st_r;

  always_comb begin
    state_nxt = state_r;
    st_nxt = st_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.idx_clr = 1'b1;
          st_nxt = ST_OK;
          case (kind_t'(in_kind))
            KIND_MAP, KIND_ADD: state_nxt = S_SRD;
            KIND_CLEAR: begin
              cmd.cnt_clr = 1'b1;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SRD: begin
        // Scan: the table is read at index, or the scan stops at the end.
        if (kind_r == KIND_MAP && sts.sparse) begin
          st_nxt = ST_SPARSE;
          state_nxt = S_DONE;
        end else if (sts.idx_at_cnt) begin
          state_nxt = (kind_r == KIND_ADD) ? S_ADDCHK : S_MRD0;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts.lt) begin
          state_nxt = (kind_r == KIND_ADD) ? S_ADDCHK : S_MRD0;
        end else if (kind_r == KIND_ADD && sts.eq) begin
          st_nxt = ST_DUP;
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_ADDCHK: begin
        if (sts.full) begin
          st_nxt = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          // Walk down from count to the insert position, shifting entries up.
          cmd.pos_cap = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.idx_cnt = 1'b1;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (sts.idx_at_pos) begin
          cmd.wr_value = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec = 1'b1;
        state_nxt = S_INS;
      end
      S_MRD0: begin
        // Index is the first point above the sample, else count.
        if (!sts.idx_zero) cmd.rd_prev = 1'b1;
        state_nxt = S_MRD1;
      end
      S_MRD1: begin
        if (sts.idx_zero || sts.idx_at_cnt) begin
          cmd.res_edge = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.cap_v0 = 1'b1;
          state_nxt = S_MRD2;
        end
      end
      S_MRD2: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[design/terrace_curve_mapper.sv]
// Top level of the terrace curve mapper.
//   Channel  Ports                               Handshake
//   input    in_kind, in_value                   start high while busy is low
//   result   out_mapped_value, out_status        out_valid high for one cycle
//   config   cfg_psel .. cfg_prdata              APB write, cfg_pready tied high
// A map item scans the held points and reads both segment ends from the table;
// the divider, the square, multiply and sum steps and the result cycle follow;
// a sample outside the held points maps to the nearest end point instead. An add
// item scans for its place, then shifts later entries up; clear and unused items
// go straight to the result cycle. busy falls after it, so items never overlap.
// Synchronous reset empties the table and clears invert; the receiver cannot stall.
`default_nettype none
module terrace_curve_mapper
  import tcm_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  output logic [31:0]      out_mapped_value,
  output logic [1:0]       out_status,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [0:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic    invert_r;
  cmd_t    cmd;
  sts_t    sts;
  status_t st;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) invert_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0)
      invert_r <= cfg_pwdata[0];
  end
  assign cfg_prdata = {31'd0, invert_r};

  tcm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_kind(in_kind), .sts(sts),
    .busy(busy), .cmd(cmd), .done(out_valid), .st_out(st)
  );

  tcm_datapath #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_value(in_value),
    .invert(invert_r), .sts(sts), .result(out_mapped_value)
  );

  assign out_status = st;

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy);
  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy);
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_mapped_value == 32'd0);
endmodule
`default_nettype wire

[verif/tb_terrace_curve_mapper.sv]
// Testbench for the terrace curve mapper: directed and random items checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_terrace_curve_mapper
  import tcm_pkg::*;
();

  localparam int NPTS = 16;
  localparam int FB   = 16;
  localparam logic [0:0] REG_INVERT = 1'b0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic [31:0] out_mapped_value;
  logic [1:0]  out_status;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  terrace_curve_mapper DUT (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic [31:0] mapped;
    status_t     status;
  } terrace_res_t;

  // Predictor state.
  logic signed [31:0] curve_pts[NPTS];
  int                 curve_cnt;
  bit                 invert_on;
  terrace_res_t       expected_q[$];
  int                 fail_cnt = 0;
  bit                 idle_gaps = 1'b1;

  function automatic terrace_res_t predict_item(kind_t k, logic signed [31:0] v);
    terrace_res_t r;
    int pos, idx;
    longint v0, v1, a, sa, prod, s;
    r.mapped = '0;
    r.status = ST_OK;
    s = v;
    if (k == KIND_MAP) begin
      if (curve_cnt < 2) r.status = ST_SPARSE;
      else begin
        idx = 0;
        while (idx < curve_cnt && !(s < curve_pts[idx])) idx++;
        if (idx == 0) r.mapped = curve_pts[0];
        else if (idx >= curve_cnt) r.mapped = curve_pts[curve_cnt-1];
        else begin
          v0 = curve_pts[idx-1];
          v1 = curve_pts[idx];
          a = ((s - v0) << FB) / (v1 - v0);
          if (invert_on) begin
            prod = v0; v0 = v1; v1 = prod;
            a = (longint'(1) << FB) - a;
          end
          sa = (a * a) >>> FB;
          prod = sa * (v1 - v0);
          r.mapped = 32'(v0 + (prod >>> FB));
        end
      end
    end else if (k == KIND_ADD) begin
      for (pos = 0; pos < curve_cnt; pos++) begin
        if (v < curve_pts[pos]) break;
        if (v == curve_pts[pos]) begin
          r.status = ST_DUP;
          return r;
        end
      end
      if (curve_cnt >= NPTS) r.status = ST_FULL;
      else begin
        for (int i = curve_cnt; i > pos; i--) curve_pts[i] = curve_pts[i-1];
        curve_pts[pos] = v;
        curve_cnt++;
      end
    end else if (k == KIND_CLEAR) curve_cnt = 0;
    return r;
  endfunction

  task automatic idle_burst();
    if (idle_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  task automatic send_item(kind_t k, logic [31:0] v);
    idle_burst();
    start    <= 1'b1;
    in_kind  <= k;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_item(k, v));
    start <= 1'b0;
    // The block stays busy for at least this cycle, so no time is lost.
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_invert(bit val);
    drain();
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= REG_INVERT;
    cfg_pwdata <= {31'b0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    invert_on = val;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker: the receiver cannot stall, so every strobe is taken.
  always @(posedge clk) begin
    terrace_res_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result mapped_value=%h status=%0d", out_mapped_value, out_status);
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (out_mapped_value !== e.mapped) begin
          $error("mapped_value expected %h actual %h", e.mapped, out_mapped_value);
          fail_cnt++;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          fail_cnt++;
        end
      end
    end
  end

  task automatic test_sparse_and_edges();
    send_item(KIND_MAP, 32'h0);
    send_item(KIND_ADD, 32'h8000_0000);
    send_item(KIND_MAP, 32'h7fff_ffff);
    send_item(KIND_ADD, 32'h7fff_ffff);
    send_item(KIND_ADD, 32'h7fff_ffff);
    send_item(KIND_MAP, 32'h8000_0000);
    send_item(KIND_MAP, 32'h7fff_ffff);
    send_item(KIND_MAP, 32'h0);
    send_item(KIND_MAP, 32'h7fff_fffe);
    send_item(KIND_NONE, 32'hffff_ffff);
    send_item(KIND_CLEAR, 32'h0);
    send_item(KIND_MAP, 32'h1234);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < NPTS; i++) send_item(KIND_ADD, 32'((NPTS - i) * 32'h0001_0000));
    send_item(KIND_ADD, 32'h0001_0000);
    send_item(KIND_ADD, 32'h0040_0000);
    send_item(KIND_MAP, 32'h0002_8000);
    send_item(KIND_MAP, 32'h0000_8000);
    send_item(KIND_MAP, 32'h0010_0000);
    send_item(KIND_CLEAR, 32'h0);
  endtask

  // Mostly well-formed sequences: build a table, then map around its points.
  task automatic test_random(int n);
    int done = 0;
    logic [31:0] v;
    while (done < n) begin
      if ($urandom_range(0, 9) == 0) send_item(KIND_CLEAR, $urandom());
      else if ($urandom_range(0, 19) == 0) send_item(KIND_NONE, $urandom());
      else if (curve_cnt < 2 || $urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0: v = $urandom();
          1: v = 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
          2: v = curve_cnt ? curve_pts[$urandom_range(0, curve_cnt-1)] : $urandom();
          default: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
        send_item(KIND_ADD, v);
      end else begin
        case ($urandom_range(0, 3))
          0: v = $urandom();
          1: v = curve_pts[$urandom_range(0, curve_cnt-1)] + 32'($urandom_range(0, 3)) - 1;
          default: v = curve_pts[$urandom_range(0, curve_cnt-2)] + ($urandom() >> $urandom_range(0, 31));
        endcase
        send_item(KIND_MAP, v);
      end
      done++;
    end
  endtask

  initial begin
    curve_cnt = 0;
    invert_on = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sparse_and_edges();
    test_full_table();
    write_invert(1'b1);
    test_sparse_and_edges();
    test_full_table();
    write_invert(1'b0);
    test_random(350);
    write_invert(1'b1);
    test_random(350);
    write_invert(1'b0);
    idle_gaps = 1'b0;
    test_random(300);
    drain();
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
